/* src/obb_pair_collision_test_top_defines.svh */
// Assertion macros shared by the oriented-box collision test checkers.
`ifndef OBB_PAIR_COLLISION_TEST_TOP_DEFINES_SVH
`define OBB_PAIR_COLLISION_TEST_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define OBBT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("obbt assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define OBBT_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("obbt reset assertion failed");

`endif

/* src/obbt_pkg.sv */
// Types and constants shared by the oriented-box collision test pipeline.
`default_nettype none
package obbt_pkg;

    localparam int SC_LAT = 4;   // sine/cosine stages
    localparam int LAT    = 12;  // total pipeline depth
    localparam int AW     = 17;  // sine, cosine and axis components
    localparam int OW     = 68;  // axis overlap
    localparam int MW     = 70;  // corner margin

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [15:0]        ang;
        logic [23:0]        w;
        logic [23:0]        h;
    } box_t;

    typedef struct packed {
        logic signed [AW-1:0] s;
        logic signed [AW-1:0] c;
    } sc_t;

    typedef struct packed {
        logic [3:0][OW-1:0] ov;
        logic [3:0]         sep;
        logic [3:0]         dneg;
        logic [3:0][AW-1:0] nx;
        logic [3:0][AW-1:0] ny;
        logic [7:0]         cin;
        logic [7:0][MW-1:0] cd;
        logic [7:0][31:0]   cpx;
        logic [7:0][31:0]   cpy;
        logic [31:0]        midx;
        logic [31:0]        midy;
    } geo_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] depth;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [31:0] contact_x;
        logic [31:0] contact_y;
    } res_t;

endpackage
`default_nettype wire

/* src/obb_pair_collision_test_top.sv */
// Oriented-box pair collision test; the whole 12-stage pipeline advances together.
// Throughput: one box pair per cycle while no finished word waits stalled at the output.
// A stalled output word freezes every stage, so s_tready follows m_tready while it waits.
// Stage split: 4 sine/cosine, 5 geometry (corners, projections, margins), 3 selection.
// Reset (rst_n low, asynchronous) clears the stage valid bits; data registers keep junk.
`default_nettype none
module obb_pair_collision_test_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_center_x, a_center_y, a_angle, a_width, a_height,
    // b_center_x, b_center_y, b_angle, b_width, b_height (lowest bits first)
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // depth, normal_x, normal_y, contact_x, contact_y, one zero pad bit
    output logic [127:0] m_tdata,
    // hit
    output logic         m_tuser
);
    import obbt_pkg::*;

    logic [LAT-1:0] vld_reg;
    logic           en;
    box_t           in_a, in_b;
    box_t           dly_a_reg [SC_LAT];
    box_t           dly_b_reg [SC_LAT];
    sc_t            sca, scb;
    geo_t           g;
    res_t           res;

    // Advance every stage unless a finished word waits at the output.
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    // Unpack the input word.
    assign in_a.cx  = s_tdata[31:0];
    assign in_a.cy  = s_tdata[63:32];
    assign in_a.ang = s_tdata[79:64];
    assign in_a.w   = s_tdata[103:80];
    assign in_a.h   = s_tdata[127:104];
    assign in_b.cx  = s_tdata[159:128];
    assign in_b.cy  = s_tdata[191:160];
    assign in_b.ang = s_tdata[207:192];
    assign in_b.w   = s_tdata[231:208];
    assign in_b.h   = s_tdata[255:232];

    // Valid bits travel alongside the data; bubbles just flow through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // Hold the raw boxes while the sine/cosine stages run.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_a_reg[0] <= in_a;
            dly_b_reg[0] <= in_b;
            for (int i = 1; i < SC_LAT; i++)
            begin
                dly_a_reg[i] <= dly_a_reg[i-1];
                dly_b_reg[i] <= dly_b_reg[i-1];
            end
        end
    end

    obbt_sincos u_sc_a (
        .clk (clk),
        .en  (en),
        .ang (in_a.ang),
        .sc  (sca)
    );

    obbt_sincos u_sc_b (
        .clk (clk),
        .en  (en),
        .ang (in_b.ang),
        .sc  (scb)
    );

    // Corners, projections on the four axes, overlaps and inside margins.
    obbt_geom u_geom (
        .clk (clk),
        .en  (en),
        .a   (dly_a_reg[SC_LAT-1]),
        .b   (dly_b_reg[SC_LAT-1]),
        .sca (sca),
        .scb (scb),
        .g   (g)
    );

    // Pick the first smallest overlap and the deepest inside corner.
    obbt_resolve u_resolve (
        .clk (clk),
        .en  (en),
        .g   (g),
        .res (res)
    );

    assign m_tdata = {1'b0, res.contact_y, res.contact_x, res.normal_y,
                      res.normal_x, res.depth};
    assign m_tuser = res.hit;

endmodule
`default_nettype wire

/* src/obbt_sincos.sv */
// Four-stage polynomial sine and cosine of a 16-bit angle, Q1.14.
`default_nettype none
module obbt_sincos (
    input  logic          clk,
    input  logic          en,
    input  logic [15:0]   ang,
    output obbt_pkg::sc_t sc
);
    import obbt_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [1:0]  q1_reg, q2_reg, q3_reg;
    logic [14:0] ta1_reg, tb1_reg, ta2_reg, tb2_reg, ta3_reg, tb3_reg;
    logic [14:0] t2a1_reg, t2b1_reg, t2a2_reg, t2b2_reg;
    logic [13:0] ina2_reg, inb2_reg;
    logic [14:0] va3_reg, vb3_reg;
    sc_t         sc_reg;

    logic [14:0] ta_next, tb_next;
    logic [29:0] sqa, sqb;
    logic [25:0] ma, mb;
    logic [28:0] pa, pb;
    logic [29:0] ra, rb;
    logic [13:0] ina_next, inb_next;
    logic [14:0] va_next, vb_next;
    logic signed [AW-1:0] s17, c17;
    sc_t         sc_next;

    always_comb
    begin
        ta_next  = {1'b0, ang[13:0]};
        tb_next  = 15'd16384 - ta_next;
        sqa      = 30'(ta_next) * 30'(ta_next);
        sqb      = 30'(tb_next) * 30'(tb_next);
        ma       = 26'(t2a1_reg) * 26'd1160;
        mb       = 26'(t2b1_reg) * 26'd1160;
        ina_next = 14'd10512 - 14'(ma[25:14]);
        inb_next = 14'd10512 - 14'(mb[25:14]);
        pa       = 29'(t2a2_reg) * 29'(ina2_reg);
        pb       = 29'(t2b2_reg) * 29'(inb2_reg);
        va_next  = 15'd25736 - pa[28:14];
        vb_next  = 15'd25736 - pb[28:14];
        ra       = 30'(ta3_reg) * 30'(va3_reg);
        rb       = 30'(tb3_reg) * 30'(vb3_reg);
        s17      = $signed({1'b0, ra[29:14]});
        c17      = $signed({1'b0, rb[29:14]});
        case (q3_reg)
            QUAD_0:  begin sc_next.s = s17;  sc_next.c = c17;  end
            QUAD_1:  begin sc_next.s = c17;  sc_next.c = -s17; end
            QUAD_2:  begin sc_next.s = -s17; sc_next.c = -c17; end
            default: begin sc_next.s = -c17; sc_next.c = s17;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg   <= ang[15:14];
            ta1_reg  <= ta_next;
            tb1_reg  <= tb_next;
            t2a1_reg <= sqa[28:14];
            t2b1_reg <= sqb[28:14];
            q2_reg   <= q1_reg;
            ta2_reg  <= ta1_reg;
            tb2_reg  <= tb1_reg;
            t2a2_reg <= t2a1_reg;
            t2b2_reg <= t2b1_reg;
            ina2_reg <= ina_next;
            inb2_reg <= inb_next;
            q3_reg   <= q2_reg;
            ta3_reg  <= ta2_reg;
            tb3_reg  <= tb2_reg;
            va3_reg  <= va_next;
            vb3_reg  <= vb_next;
            sc_reg   <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule
`default_nettype wire

/* src/obbt_geom.sv */
// Five-stage geometry: corners, projections, intervals, overlaps and corner margins.
`default_nettype none
module obbt_geom (
    input  logic           clk,
    input  logic           en,
    input  obbt_pkg::box_t a,
    input  obbt_pkg::box_t b,
    input  obbt_pkg::sc_t  sca,
    input  obbt_pkg::sc_t  scb,
    output obbt_pkg::geo_t g
);
    import obbt_pkg::*;

    localparam logic [3:0] SGX_POS = 4'b0110;  // corners with +w
    localparam logic [3:0] SGY_POS = 4'b1100;  // corners with +h

    typedef struct packed {
        logic [1:0][23:0]   w;
        logic [1:0][23:0]   h;
        logic [31:0]        midx;
        logic [31:0]        midy;
    } cry_t;

    // stage 1
    logic signed [41:0] cw_reg [2], ch_reg [2], sw_reg [2], sh_reg [2];
    logic signed [46:0] bx_reg [2], by_reg [2];
    logic signed [47:0] dbx_reg [2], dby_reg [2];
    logic signed [AW-1:0] s1_reg [2], c1_reg [2];
    logic signed [32:0] dcx1_reg, dcy1_reg;
    cry_t cry1_reg;
    // stage 2
    logic signed [48:0] px_reg [8], py_reg [8];
    logic signed [49:0] dx_reg [8], dy_reg [8];
    logic signed [AW-1:0] s2_reg [2], c2_reg [2];
    logic signed [32:0] dcx2_reg, dcy2_reg;
    cry_t cry2_reg;
    // stage 3
    logic signed [66:0] pj_reg [4][8];
    logic signed [67:0] lx_reg [8], ly_reg [8];
    logic [3:0] dneg3_reg;
    logic [3:0][AW-1:0] nx3_reg, ny3_reg;
    logic [7:0][31:0] cpx3_reg, cpy3_reg;
    cry_t cry3_reg;
    // stage 4
    logic signed [66:0] lo_reg [4][2], hi_reg [4][2];
    logic [67:0] alx_reg [8], aly_reg [8];
    logic [3:0] dneg4_reg;
    logic [3:0][AW-1:0] nx4_reg, ny4_reg;
    logic [7:0][31:0] cpx4_reg, cpy4_reg;
    cry_t cry4_reg;
    // stage 5
    geo_t g_reg, g_next;

    box_t bxi [2];
    logic signed [AW-1:0] s_in [2], c_in [2];
    logic signed [41:0] cw_next [2], ch_next [2], sw_next [2], sh_next [2];
    logic signed [46:0] bx_next [2], by_next [2];
    logic signed [47:0] dbx_next [2], dby_next [2];
    logic signed [32:0] sumx, sumy;
    cry_t cry1_next;
    logic signed [43:0] ox [8], oy [8];
    logic signed [48:0] px_next [8], py_next [8];
    logic signed [49:0] dx_next [8], dy_next [8];
    logic signed [AW-1:0] axx [4], axy [4];
    logic signed [66:0] pj_next [4][8];
    logic signed [67:0] lx_next [8], ly_next [8];
    logic signed [50:0] dot [4];
    logic [3:0] dneg_next;
    logic [7:0][31:0] cpx_next, cpy_next;
    logic signed [66:0] lo_next [4][2], hi_next [4][2];
    logic [67:0] alx_next [8], aly_next [8];
    logic [MW-1:0] mx, my;

    function automatic logic [31:0] sat34(input logic signed [48:0] v);
        logic [33:0] t;
        t = v[48:15];
        if (t[33:31] == 3'b000 || t[33:31] == 3'b111)
            sat34 = t[31:0];
        else
            sat34 = t[33] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    function automatic logic signed [66:0] min2(input logic signed [66:0] x,
                                                input logic signed [66:0] y);
        min2 = (y < x) ? y : x;
    endfunction

    function automatic logic signed [66:0] max2(input logic signed [66:0] x,
                                                input logic signed [66:0] y);
        max2 = (y > x) ? y : x;
    endfunction

    assign bxi[0]  = a;
    assign bxi[1]  = b;
    assign s_in[0] = sca.s;
    assign c_in[0] = sca.c;
    assign s_in[1] = scb.s;
    assign c_in[1] = scb.c;

    // stage 1: rotated half sizes, scaled centres
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            cw_next[k]  = c_in[k] * $signed({1'b0, bxi[k].w});
            ch_next[k]  = c_in[k] * $signed({1'b0, bxi[k].h});
            sw_next[k]  = s_in[k] * $signed({1'b0, bxi[k].w});
            sh_next[k]  = s_in[k] * $signed({1'b0, bxi[k].h});
            bx_next[k]  = {bxi[k].cx, 15'b0};
            by_next[k]  = {bxi[k].cy, 15'b0};
            dbx_next[k] = {bxi[k].cx[31], bxi[k].cx, 15'b0}
                        - {bxi[1-k].cx[31], bxi[1-k].cx, 15'b0};
            dby_next[k] = {bxi[k].cy[31], bxi[k].cy, 15'b0}
                        - {bxi[1-k].cy[31], bxi[1-k].cy, 15'b0};
            cry1_next.w[k] = bxi[k].w;
            cry1_next.h[k] = bxi[k].h;
        end
        sumx = {a.cx[31], a.cx} + {b.cx[31], b.cx};
        sumy = {a.cy[31], a.cy} + {b.cy[31], b.cy};
        cry1_next.midx = sumx[32:1];
        cry1_next.midy = sumy[32:1];
    end

    // stage 2: corners, absolute and relative to the other centre
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            ox[j] = (SGX_POS[j%4] ? 44'(cw_reg[j/4]) : -44'(cw_reg[j/4]))
                  - (SGY_POS[j%4] ? 44'(sh_reg[j/4]) : -44'(sh_reg[j/4]));
            oy[j] = (SGX_POS[j%4] ? 44'(sw_reg[j/4]) : -44'(sw_reg[j/4]))
                  + (SGY_POS[j%4] ? 44'(ch_reg[j/4]) : -44'(ch_reg[j/4]));
            px_next[j] = 49'(bx_reg[j/4]) + 49'(ox[j]);
            py_next[j] = 49'(by_reg[j/4]) + 49'(oy[j]);
            dx_next[j] = 50'(dbx_reg[j/4]) + 50'(ox[j]);
            dy_next[j] = 50'(dby_reg[j/4]) + 50'(oy[j]);
        end
    end

    // stage 3: projections on the four axes, corners in the other box frame
    always_comb
    begin
        axx[0] = c2_reg[0];  axy[0] = s2_reg[0];
        axx[1] = -s2_reg[0]; axy[1] = c2_reg[0];
        axx[2] = c2_reg[1];  axy[2] = s2_reg[1];
        axx[3] = -s2_reg[1]; axy[3] = c2_reg[1];
        for (int x = 0; x < 4; x++)
        begin
            for (int j = 0; j < 8; j++)
                pj_next[x][j] = 67'(px_reg[j]) * 67'(axx[x])
                              + 67'(py_reg[j]) * 67'(axy[x]);
            dot[x] = 51'(dcx2_reg) * 51'(axx[x]) + 51'(dcy2_reg) * 51'(axy[x]);
            dneg_next[x] = dot[x][50];
        end
        for (int j = 0; j < 8; j++)
        begin
            lx_next[j] = 68'(c2_reg[1-j/4]) * 68'(dx_reg[j])
                       + 68'(s2_reg[1-j/4]) * 68'(dy_reg[j]);
            ly_next[j] = 68'(c2_reg[1-j/4]) * 68'(dy_reg[j])
                       - 68'(s2_reg[1-j/4]) * 68'(dx_reg[j]);
            cpx_next[j] = sat34(px_reg[j]);
            cpy_next[j] = sat34(py_reg[j]);
        end
    end

    // stage 4: projection intervals, absolute local offsets
    always_comb
    begin
        for (int x = 0; x < 4; x++)
            for (int k = 0; k < 2; k++)
            begin
                lo_next[x][k] = min2(min2(pj_reg[x][4*k], pj_reg[x][4*k+1]),
                                     min2(pj_reg[x][4*k+2], pj_reg[x][4*k+3]));
                hi_next[x][k] = max2(max2(pj_reg[x][4*k], pj_reg[x][4*k+1]),
                                     max2(pj_reg[x][4*k+2], pj_reg[x][4*k+3]));
            end
        for (int j = 0; j < 8; j++)
        begin
            alx_next[j] = lx_reg[j][67] ? 68'(-lx_reg[j]) : 68'(lx_reg[j]);
            aly_next[j] = ly_reg[j][67] ? 68'(-ly_reg[j]) : 68'(ly_reg[j]);
        end
    end

    // stage 5: separation, overlap, strict-inside margins
    always_comb
    begin
        g_next = '0;
        for (int x = 0; x < 4; x++)
        begin
            g_next.sep[x] = (hi_reg[x][0] < lo_reg[x][1]) || (hi_reg[x][1] < lo_reg[x][0]);
            g_next.ov[x]  = 68'(min2(hi_reg[x][0], hi_reg[x][1]))
                          - 68'(max2(lo_reg[x][0], lo_reg[x][1]));
        end
        mx = '0;
        my = '0;
        for (int j = 0; j < 8; j++)
        begin
            mx = {18'b0, cry4_reg.w[1-j/4], 28'b0} - {2'b0, alx_reg[j]};
            my = {18'b0, cry4_reg.h[1-j/4], 28'b0} - {2'b0, aly_reg[j]};
            g_next.cin[j] = !mx[MW-1] && (mx != '0) && !my[MW-1] && (my != '0);
            g_next.cd[j]  = (my < mx) ? my : mx;
        end
        g_next.dneg = dneg4_reg;
        g_next.nx   = nx4_reg;
        g_next.ny   = ny4_reg;
        g_next.cpx  = cpx4_reg;
        g_next.cpy  = cpy4_reg;
        g_next.midx = cry4_reg.midx;
        g_next.midy = cry4_reg.midy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                cw_reg[k]  <= cw_next[k];
                ch_reg[k]  <= ch_next[k];
                sw_reg[k]  <= sw_next[k];
                sh_reg[k]  <= sh_next[k];
                bx_reg[k]  <= bx_next[k];
                by_reg[k]  <= by_next[k];
                dbx_reg[k] <= dbx_next[k];
                dby_reg[k] <= dby_next[k];
                s1_reg[k]  <= s_in[k];
                c1_reg[k]  <= c_in[k];
                s2_reg[k]  <= s1_reg[k];
                c2_reg[k]  <= c1_reg[k];
            end
            dcx1_reg <= {a.cx[31], a.cx} - {b.cx[31], b.cx};
            dcy1_reg <= {a.cy[31], a.cy} - {b.cy[31], b.cy};
            cry1_reg <= cry1_next;
            for (int j = 0; j < 8; j++)
            begin
                px_reg[j]  <= px_next[j];
                py_reg[j]  <= py_next[j];
                dx_reg[j]  <= dx_next[j];
                dy_reg[j]  <= dy_next[j];
                lx_reg[j]  <= lx_next[j];
                ly_reg[j]  <= ly_next[j];
                alx_reg[j] <= alx_next[j];
                aly_reg[j] <= aly_next[j];
            end
            dcx2_reg <= dcx1_reg;
            dcy2_reg <= dcy1_reg;
            cry2_reg <= cry1_reg;
            for (int x = 0; x < 4; x++)
            begin
                for (int j = 0; j < 8; j++)
                    pj_reg[x][j] <= pj_next[x][j];
                for (int k = 0; k < 2; k++)
                begin
                    lo_reg[x][k] <= lo_next[x][k];
                    hi_reg[x][k] <= hi_next[x][k];
                end
                nx3_reg[x] <= axx[x];
                ny3_reg[x] <= axy[x];
            end
            dneg3_reg <= dneg_next;
            cpx3_reg  <= cpx_next;
            cpy3_reg  <= cpy_next;
            cry3_reg  <= cry2_reg;
            dneg4_reg <= dneg3_reg;
            nx4_reg   <= nx3_reg;
            ny4_reg   <= ny3_reg;
            cpx4_reg  <= cpx3_reg;
            cpy4_reg  <= cpy3_reg;
            cry4_reg  <= cry3_reg;
            g_reg     <= g_next;
        end
    end

    assign g = g_reg;

endmodule
`default_nettype wire

/* src/obbt_resolve.sv */
// Three-stage selection of the contact axis and the deepest inside corner.
`default_nettype none
module obbt_resolve (
    input  logic           clk,
    input  logic           en,
    input  obbt_pkg::geo_t g,
    output obbt_pkg::res_t res
);
    import obbt_pkg::*;

    // stage 1
    logic [OW-1:0] aov1_reg [2];
    logic [1:0]    aix1_reg [2];
    logic          cv1_reg [4];
    logic [MW-1:0] cd1_reg [4];
    logic [31:0]   cx1_reg [4], cy1_reg [4];
    logic [3:0]    sep1_reg, dneg1_reg;
    logic [3:0][AW-1:0] nx1_reg, ny1_reg;
    logic [31:0]   mx1_reg, my1_reg;
    // stage 2
    logic [OW-1:0] aov2_reg;
    logic [1:0]    aix2_reg;
    logic          cv2_reg [2];
    logic [MW-1:0] cd2_reg [2];
    logic [31:0]   cx2_reg [2], cy2_reg [2];
    logic [3:0]    sep2_reg, dneg2_reg;
    logic [3:0][AW-1:0] nx2_reg, ny2_reg;
    logic [31:0]   mx2_reg, my2_reg;
    // stage 3
    res_t res_reg, res_next;

    logic          tk1 [4];
    logic          tk2 [2];
    logic          tk3;
    logic          ap1 [2];
    logic          ap2;
    logic signed [AW-1:0] nsel_x, nsel_y;

    always_comb
    begin
        for (int p = 0; p < 2; p++)
            ap1[p] = $signed(g.ov[2*p+1]) < $signed(g.ov[2*p]);
        ap2 = $signed(aov1_reg[1]) < $signed(aov1_reg[0]);
        // a later corner wins only if strictly deeper
        for (int p = 0; p < 4; p++)
            tk1[p] = g.cin[2*p+1] && (!g.cin[2*p] || (g.cd[2*p+1] > g.cd[2*p]));
        for (int p = 0; p < 2; p++)
            tk2[p] = cv1_reg[2*p+1] && (!cv1_reg[2*p] || (cd1_reg[2*p+1] > cd1_reg[2*p]));
        tk3 = cv2_reg[1] && (!cv2_reg[0] || (cd2_reg[1] > cd2_reg[0]));

        nsel_x = dneg2_reg[aix2_reg] ? -$signed(nx2_reg[aix2_reg])
                                     : $signed(nx2_reg[aix2_reg]);
        nsel_y = dneg2_reg[aix2_reg] ? -$signed(ny2_reg[aix2_reg])
                                     : $signed(ny2_reg[aix2_reg]);
        res_next = '0;
        if (sep2_reg == 4'b0000)
        begin
            res_next.hit      = 1'b1;
            res_next.depth    = (|aov2_reg[OW-2:60]) ? 31'h7fff_ffff : aov2_reg[59:29];
            res_next.normal_x = nsel_x[15:0];
            res_next.normal_y = nsel_y[15:0];
            if (cv2_reg[0] || cv2_reg[1])
            begin
                res_next.contact_x = tk3 ? cx2_reg[1] : cx2_reg[0];
                res_next.contact_y = tk3 ? cy2_reg[1] : cy2_reg[0];
            end
            else
            begin
                res_next.contact_x = mx2_reg;
                res_next.contact_y = my2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < 2; p++)
            begin
                aov1_reg[p] <= ap1[p] ? g.ov[2*p+1] : g.ov[2*p];
                aix1_reg[p] <= ap1[p] ? 2'(2*p+1) : 2'(2*p);
                cv2_reg[p]  <= cv1_reg[2*p] || cv1_reg[2*p+1];
                cd2_reg[p]  <= tk2[p] ? cd1_reg[2*p+1] : cd1_reg[2*p];
                cx2_reg[p]  <= tk2[p] ? cx1_reg[2*p+1] : cx1_reg[2*p];
                cy2_reg[p]  <= tk2[p] ? cy1_reg[2*p+1] : cy1_reg[2*p];
            end
            for (int p = 0; p < 4; p++)
            begin
                cv1_reg[p] <= g.cin[2*p] || g.cin[2*p+1];
                cd1_reg[p] <= tk1[p] ? g.cd[2*p+1]  : g.cd[2*p];
                cx1_reg[p] <= tk1[p] ? g.cpx[2*p+1] : g.cpx[2*p];
                cy1_reg[p] <= tk1[p] ? g.cpy[2*p+1] : g.cpy[2*p];
            end
            sep1_reg  <= g.sep;
            dneg1_reg <= g.dneg;
            nx1_reg   <= g.nx;
            ny1_reg   <= g.ny;
            mx1_reg   <= g.midx;
            my1_reg   <= g.midy;
            aov2_reg  <= ap2 ? aov1_reg[1] : aov1_reg[0];
            aix2_reg  <= ap2 ? aix1_reg[1] : aix1_reg[0];
            sep2_reg  <= sep1_reg;
            dneg2_reg <= dneg1_reg;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            mx2_reg   <= mx1_reg;
            my2_reg   <= my1_reg;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

/* src/obbt_checker.sv */
// Port-level checker for the collision test top, bound to it.
`default_nettype none
`include "obb_pair_collision_test_top_defines.svh"
module obbt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    `OBBT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)
    `OBBT_ASSERT(a_stall_blocks_in, m_tvalid && !m_tready |-> !s_tready)
    `OBBT_ASSERT(a_miss_zero, m_tvalid && !m_tuser |-> m_tdata == '0)
    `OBBT_ASSERT_RST(a_reset_quiet, !rst_n |-> !m_tvalid)

endmodule

bind obb_pair_collision_test_top obbt_checker u_obbt_checker (.*);
`default_nettype wire
